// ===== sv/fpa_pkg.sv =====
// Shared types and codes for the Q24.8 fixed-point ALU.
// Holds the operation codes and the request and response payload structs.
// No dependencies.
package fpa_pkg;

   // Operation select codes carried in the request
   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   localparam int unsigned DataWidth = 32;

   // Request payload: operation and two raw fixed-point operands
   typedef struct packed {
      op_type                      op;
      logic signed [DataWidth-1:0] operand_a;
      logic signed [DataWidth-1:0] operand_b;
   } req_type;

   // Response payload: raw result and status flags
   typedef struct packed {
      logic signed [DataWidth-1:0] result;
      logic                        compare_true;
      logic                        divide_by_zero;
   } rsp_type;

endpackage

// ===== sv/fixed_point_alu_q24_8.sv =====
// Pipelined signed 32-bit fixed-point ALU with a one-bit-per-stage divider.
// Depends on fpa_pkg for the operation codes and payload structs.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start is high and busy low
//   response  rsp_valid, rsp_data        one-cycle strobe, no back pressure
//
// Each request passes through the request capture, execute, divider and response
// registers before its response strobe; one request may enter on every cycle.
// The pipe depth is set by the restoring divider: one quotient bit per stage over
// a 32 + FRAC_BITS bit numerator; all other ops ride the same pipe to keep order.
// Reset clears only the valid bits; payload registers carry no reset.
// Busy stays low: the pipe never stalls since the receiver cannot hold results.
module fixed_point_alu_q24_8 #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fpa_pkg::req_type req_data,
   output logic             rsp_valid,
   output fpa_pkg::rsp_type rsp_data
);

   localparam int unsigned DataWidth = fpa_pkg::DataWidth;
   localparam int unsigned NumWidth  = DataWidth + FRAC_BITS;
   localparam int unsigned Latency   = NumWidth + 3;

   // Per-stage payload of the divider pipe
   typedef struct packed {
      fpa_pkg::op_type       op;
      logic [DataWidth-1:0]  res;
      logic                  cmp;
      logic                  dz;
      logic                  neg;
      logic [DataWidth-1:0]  rem;
      logic [NumWidth-1:0]   num;
      logic [DataWidth-1:0]  den;
   } div_stage_type;

   // Operand decode stage payload
   typedef struct packed {
      fpa_pkg::op_type               op;
      logic [DataWidth-1:0]          res;
      logic                          cmp;
      logic                          dz;
      logic                          neg;
      logic signed [2*DataWidth-1:0] prod;
      logic [NumWidth-1:0]           num;
      logic [DataWidth-1:0]          den;
   } exe_stage_type;

   logic                  req_accept;
   logic [Latency-1:0]    vld_ff;
   logic [Latency-1:0]    vld_in;
   fpa_pkg::req_type      in_ff;
   exe_stage_type         exe_ff;
   exe_stage_type         exe_in;
   div_stage_type         div_src [NumWidth];
   div_stage_type         div_in  [NumWidth];
   div_stage_type         div_ff  [NumWidth];
   fpa_pkg::rsp_type      rsp_ff;
   fpa_pkg::rsp_type      rsp_in;

   assign busy       = 1'b0;
   assign req_accept = start & ~busy;

   // Advance the valid bits alongside the payload
   assign vld_in = {vld_ff[Latency-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      in_ff <= req_data;
   end

   // Execute: simple ops, full product and divider operand setup
   always_comb begin
      logic signed [DataWidth-1:0] sa;
      logic signed [DataWidth-1:0] sb;
      logic                        lt;
      logic                        gt;
      logic                        eq;
      sa = in_ff.operand_a;
      sb = in_ff.operand_b;
      lt = sa < sb;
      gt = sa > sb;
      eq = sa == sb;
      exe_in.op   = in_ff.op;
      exe_in.res  = '0;
      exe_in.cmp  = 1'b0;
      exe_in.dz   = 1'b0;
      exe_in.neg  = sa[DataWidth-1] ^ sb[DataWidth-1];
      exe_in.prod = sa * sb;
      exe_in.num  = {(sa[DataWidth-1] ? DataWidth'(-sa) : DataWidth'(sa)),
                     {FRAC_BITS{1'b0}}};
      exe_in.den  = sb[DataWidth-1] ? DataWidth'(-sb) : DataWidth'(sb);
      case (in_ff.op)
         fpa_pkg::OP_ADD:      exe_in.res = DataWidth'(sa + sb);
         fpa_pkg::OP_SUB:      exe_in.res = DataWidth'(sa - sb);
         fpa_pkg::OP_MUL:      exe_in.res = '0;
         fpa_pkg::OP_DIV:      exe_in.dz  = (sb == '0);
         fpa_pkg::OP_GT:       exe_in.cmp = gt;
         fpa_pkg::OP_LT:       exe_in.cmp = lt;
         fpa_pkg::OP_GE:       exe_in.cmp = ~lt;
         fpa_pkg::OP_LE:       exe_in.cmp = ~gt;
         fpa_pkg::OP_EQ:       exe_in.cmp = eq;
         fpa_pkg::OP_NE:       exe_in.cmp = ~eq;
         fpa_pkg::OP_MIN:      exe_in.res = lt ? sa : sb;
         fpa_pkg::OP_MAX:      exe_in.res = gt ? sa : sb;
         fpa_pkg::OP_INC:      exe_in.res = DataWidth'(sa + 32'sd1);
         fpa_pkg::OP_DEC:      exe_in.res = DataWidth'(sa - 32'sd1);
         fpa_pkg::OP_FROM_INT: exe_in.res = sa <<< FRAC_BITS;
         fpa_pkg::OP_TO_INT:   exe_in.res = sa >>> FRAC_BITS;
         default:              exe_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      exe_ff <= exe_in;
   end

   // Feed the first divider stage; scale the product back for multiply
   always_comb begin
      logic signed [2*DataWidth-1:0] scaled;
      scaled = exe_ff.prod >>> FRAC_BITS;
      div_src[0].op  = exe_ff.op;
      div_src[0].res = (exe_ff.op == fpa_pkg::OP_MUL) ? scaled[DataWidth-1:0] : exe_ff.res;
      div_src[0].cmp = exe_ff.cmp;
      div_src[0].dz  = exe_ff.dz;
      div_src[0].neg = exe_ff.neg;
      div_src[0].rem = '0;
      div_src[0].num = exe_ff.num;
      div_src[0].den = exe_ff.den;
   end

   // Restoring divider: one quotient bit per stage, shifted into num
   for (genvar i = 0; i < NumWidth; i++) begin : g_div
      if (i > 0) begin : g_link
         assign div_src[i] = div_ff[i-1];
      end

      always_comb begin
         logic [DataWidth:0] trial;
         logic [DataWidth:0] diff;
         logic               fit;
         trial = {div_src[i].rem, div_src[i].num[NumWidth-1]};
         diff  = trial - {1'b0, div_src[i].den};
         fit   = ~diff[DataWidth];
         div_in[i]     = div_src[i];
         div_in[i].rem = fit ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
         div_in[i].num = {div_src[i].num[NumWidth-2:0], fit};
      end

      always_ff @(posedge clock) begin
         div_ff[i] <= div_in[i];
      end
   end

   // Sign-correct the quotient and select the final result
   always_comb begin
      logic [DataWidth-1:0] quot;
      quot = div_ff[NumWidth-1].num[DataWidth-1:0];
      rsp_in.compare_true   = div_ff[NumWidth-1].cmp;
      rsp_in.divide_by_zero = div_ff[NumWidth-1].dz;
      if (div_ff[NumWidth-1].op == fpa_pkg::OP_DIV) begin
         if (div_ff[NumWidth-1].dz) begin
            rsp_in.result = '0;
         end else begin
            rsp_in.result = div_ff[NumWidth-1].neg ? DataWidth'(-quot) : quot;
         end
      end else begin
         rsp_in.result = div_ff[NumWidth-1].res;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[Latency-1];
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Every response strobe traces back to an accepted request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, Latency))
      else $error("response without a matching request");

   // Divide by zero forces a zero result and no compare flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_by_zero) |->
         (rsp_data.result == '0 && !rsp_data.compare_true))
      else $error("divide by zero response carries data");

   // Compare flag only for comparison requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.compare_true) |->
         ($past(req_data.op, Latency) == fpa_pkg::OP_GT ||
          $past(req_data.op, Latency) == fpa_pkg::OP_LT ||
          $past(req_data.op, Latency) == fpa_pkg::OP_GE ||
          $past(req_data.op, Latency) == fpa_pkg::OP_LE ||
          $past(req_data.op, Latency) == fpa_pkg::OP_EQ ||
          $past(req_data.op, Latency) == fpa_pkg::OP_NE))
      else $error("compare flag on a non-compare request");

   // Divide-by-zero flag only for a divide request with a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_by_zero) |->
         ($past(req_data.op, Latency) == fpa_pkg::OP_DIV &&
          $past(req_data.operand_b, Latency) == '0))
      else $error("divide-by-zero flag without a zero divisor");
`endif

endmodule
